// ----- rtl/y2r_pkg.sv -----
// Shared types and constants for the YUYV to RGB565 converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package y2r_pkg;

  localparam int CFG_W     = 12;
  localparam int ADDR_W    = 22;
  localparam int ACC_W     = 20;
  localparam int REG_IDX_W = 2;

  localparam int DEF_MAX_LINE_PIXELS = 2048;
  localparam int DEF_MAX_LINES       = 2048;
  localparam int QUEUE_DEPTH         = 4;

  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FB_WIDTH     = 2'd2;

  localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 12'd800;
  localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 12'd600;
  localparam logic [CFG_W-1:0] RST_FB_WIDTH     = 12'd800;

  typedef struct packed {
    logic [CFG_W-1:0] image_width;
    logic [CFG_W-1:0] image_height;
    logic [CFG_W-1:0] fb_width;
  } cfg_t;

  // One pixel pair that survived the crop, with its framebuffer address.
  typedef struct packed {
    logic [ADDR_W-1:0] fb_address;
    logic [7:0]        luma_first;
    logic [7:0]        chroma_blue;
    logic [7:0]        luma_second;
    logic [7:0]        chroma_red;
  } word_t;

endpackage

`default_nettype wire

// ----- rtl/yuyv_to_rgb565_converter.sv -----
// Top level of the YUYV 4:2:2 to RGB565 converter with framebuffer addressing.
// Depends on y2r_pkg, y2r_front, y2r_queue and y2r_back.
//
// Usage:
//   s_* stream: one YUYV pixel pair per word, row by row. s_tdata bits
//     [7:0] Y0, [15:8] U, [23:16] Y1, [31:24] V.
//   m_* stream: one word per pair inside the framebuffer width; pairs at or
//     past fb_width are dropped. m_tdata bits [21:0] pixel address of the
//     first pixel, [37:22] first RGB565 pixel, [53:38] second, rest zero.
//   cfg_*: write port, index 0 image_width, 1 image_height, 2 fb_width;
//     write while the block is idle.
// Throughput: one word per cycle unless m_tready stalls the output, set by the
//   counter update per word in the front end and fully pipelined back-end conversion.
// Path to m_tvalid: queue entry, stage s1, output register; an output stall holds the word.
// Reset: counters cleared, registers back to 800/600/800, queue emptied.
// Stall: m_tready low holds the output word; the back end stops, the
//   4-deep queue fills, and then s_tready drops.
`default_nettype none

module yuyv_to_rgb565_converter #(
  parameter int MAX_LINE_PIXELS = y2r_pkg::DEF_MAX_LINE_PIXELS,
  parameter int MAX_LINES       = y2r_pkg::DEF_MAX_LINES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [31:0]                     s_tdata,  // luma_first, chroma_blue, luma_second, chroma_red
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [55:0]                     m_tdata,  // fb_address, pixel_first, pixel_second
  input  logic                            cfg_we,
  input  logic [y2r_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [y2r_pkg::CFG_W-1:0]       cfg_data
);
  import y2r_pkg::*;

  cfg_t  cfg;
  logic  push, queue_full, head_valid, pop;
  word_t push_word, head_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= RST_IMAGE_WIDTH;
      cfg.image_height <= RST_IMAGE_HEIGHT;
      cfg.fb_width     <= RST_FB_WIDTH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data;
        REG_FB_WIDTH:     cfg.fb_width     <= cfg_data;
        default:          ;
      endcase
    end
  end

  y2r_front #(
    .MAX_LINE_PIXELS (MAX_LINE_PIXELS),
    .MAX_LINES       (MAX_LINES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .queue_full (queue_full),
    .push       (push),
    .push_word  (push_word)
  );

  y2r_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_word  (push_word),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_word  (head_word)
  );

  y2r_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_word  (head_word),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

`default_nettype wire

// ----- rtl/y2r_front.sv -----
// Front end: accepts YUYV words, runs column/row counters, crops and addresses.
// Depends on y2r_pkg; feeds y2r_queue.
`default_nettype none

module y2r_front #(
  parameter int MAX_LINE_PIXELS = y2r_pkg::DEF_MAX_LINE_PIXELS,
  parameter int MAX_LINES       = y2r_pkg::DEF_MAX_LINES
) (
  input  logic           clk,
  input  logic           rst,
  input  y2r_pkg::cfg_t  cfg,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [31:0]    s_tdata,
  input  logic           queue_full,
  output logic           push,
  output y2r_pkg::word_t push_word
);
  import y2r_pkg::*;

  localparam int MAX_PAIRS = MAX_LINE_PIXELS / 2;
  localparam int COL_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int ROW_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int CW = (COL_W + 1 > CFG_W + 1) ? COL_W + 1 : CFG_W + 1;
  localparam int RW = (ROW_W + 1 > CFG_W + 1) ? ROW_W + 1 : CFG_W + 1;

  logic [COL_W-1:0]  pair_column, pair_column_next;
  logic [ROW_W-1:0]  row_index, row_index_next;
  logic [ADDR_W-1:0] row_base_address, row_base_address_next;

  logic [CW-1:0]    pairs_raw, pairs_sat, pairs, col_inc, col_x2;
  logic [RW-1:0]    rows_raw, rows_sat, rows, row_inc;
  logic [CFG_W:0]   pitch;
  logic             accept, keep, row_end, frame_end;

  assign s_tready = !queue_full;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    pairs_raw = CW'(cfg.image_width[CFG_W-1:1]);
    pairs_sat = (pairs_raw > CW'(MAX_PAIRS)) ? CW'(MAX_PAIRS) : pairs_raw;
    pairs     = (pairs_sat == '0) ? CW'(1) : pairs_sat;
    rows_raw  = RW'(cfg.image_height);
    rows_sat  = (rows_raw > RW'(MAX_LINES)) ? RW'(MAX_LINES) : rows_raw;
    rows      = (rows_sat == '0) ? RW'(1) : rows_sat;
    pitch     = ({1'b0, cfg.fb_width} + (CFG_W + 1)'(1)) & ~((CFG_W + 1)'(1));

    col_x2    = CW'({pair_column, 1'b0});
    col_inc   = CW'(pair_column) + CW'(1);
    row_inc   = RW'(row_index) + RW'(1);
    keep      = col_x2 < CW'(cfg.fb_width);
    row_end   = col_inc >= pairs;
    frame_end = row_inc >= rows;

    pair_column_next      = COL_W'(col_inc);
    row_index_next        = row_index;
    row_base_address_next = row_base_address;
    if (row_end) begin
      pair_column_next = '0;
      if (frame_end) begin
        row_index_next        = '0;
        row_base_address_next = '0;
      end else begin
        row_index_next        = ROW_W'(row_inc);
        row_base_address_next = row_base_address + ADDR_W'(pitch);
      end
    end
  end

  assign push                   = accept && keep;
  assign push_word.fb_address   = row_base_address + ADDR_W'(col_x2);
  assign push_word.luma_first   = s_tdata[7:0];
  assign push_word.chroma_blue  = s_tdata[15:8];
  assign push_word.luma_second  = s_tdata[23:16];
  assign push_word.chroma_red   = s_tdata[31:24];

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_column      <= '0;
      row_index        <= '0;
      row_base_address <= '0;
    end else if (accept) begin
      pair_column      <= pair_column_next;
      row_index        <= row_index_next;
      row_base_address <= row_base_address_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/y2r_queue.sv -----
// Short FIFO between front and back ends of the converter.
// Depends on y2r_pkg for the word type and depth.
`default_nettype none

module y2r_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  y2r_pkg::word_t push_word,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output y2r_pkg::word_t head_word
);
  import y2r_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  word_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_pop;

  assign full       = count == (PTR_W + 1)'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_word  = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({push, do_pop})
        2'b10:   count <= count + (PTR_W + 1)'(1);
        2'b01:   count <= count - (PTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/y2r_back.sv -----
// Back end: BT.601 YUV to RGB565 conversion; two pipeline stages, s1 and output register.
// Depends on y2r_pkg; drains y2r_queue.
`default_nettype none

module y2r_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  y2r_pkg::word_t head_word,
  output logic           pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [55:0]    m_tdata
);
  import y2r_pkg::*;

  localparam logic signed [ACC_W-1:0] K_Y  = ACC_W'(298);
  localparam logic signed [ACC_W-1:0] K_RV = ACC_W'(409);
  localparam logic signed [ACC_W-1:0] K_GU = ACC_W'(100);
  localparam logic signed [ACC_W-1:0] K_GV = ACC_W'(208);
  localparam logic signed [ACC_W-1:0] K_BU = ACC_W'(516);
  localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(128);

  function automatic logic [7:0] clamp8(input logic signed [ACC_W-1:0] acc);
    logic [7:0] v;
    if (acc[ACC_W-1]) begin
      v = 8'd0;
    end else if (|acc[ACC_W-2:16]) begin
      v = 8'd255;
    end else begin
      v = acc[15:8];
    end
    return v;
  endfunction

  function automatic logic [15:0] pack565(
    input logic signed [ACC_W-1:0] yc,
    input logic signed [ACC_W-1:0] rv,
    input logic signed [ACC_W-1:0] gu,
    input logic signed [ACC_W-1:0] gv,
    input logic signed [ACC_W-1:0] bu
  );
    logic [7:0] r, g, b;
    r = clamp8(yc + rv + ROUND);
    g = clamp8(yc - gu - gv + ROUND);
    b = clamp8(yc + bu + ROUND);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  logic signed [9:0] c0, c1;
  logic signed [8:0] d, e;

  logic                     s1_valid;
  logic [ADDR_W-1:0]        s1_addr;
  logic signed [ACC_W-1:0]  s1_y0, s1_y1, s1_rv, s1_gu, s1_gv, s1_bu;
  logic                     can_out, adv1;

  assign c0 = $signed({2'b00, head_word.luma_first}) - 10'sd16;
  assign c1 = $signed({2'b00, head_word.luma_second}) - 10'sd16;
  assign d  = $signed({1'b0, head_word.chroma_blue}) - 9'sd128;
  assign e  = $signed({1'b0, head_word.chroma_red}) - 9'sd128;

  assign can_out = !m_tvalid || m_tready;
  assign adv1    = !s1_valid || can_out;
  assign pop     = head_valid && adv1;

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_addr <= head_word.fb_address;
      s1_y0   <= K_Y * ACC_W'(c0);
      s1_y1   <= K_Y * ACC_W'(c1);
      s1_rv   <= K_RV * ACC_W'(e);
      s1_gu   <= K_GU * ACC_W'(d);
      s1_gv   <= K_GV * ACC_W'(e);
      s1_bu   <= K_BU * ACC_W'(d);
    end
    if (can_out) begin
      // bits: fb_address[21:0], pixel_first[37:22], pixel_second[53:38]
      m_tdata <= {2'b00,
                  pack565(s1_y1, s1_rv, s1_gu, s1_gv, s1_bu),
                  pack565(s1_y0, s1_rv, s1_gu, s1_gv, s1_bu),
                  s1_addr};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid <= head_valid;
      end
      if (can_out) begin
        m_tvalid <= s1_valid;
      end
    end
  end

endmodule

`default_nettype wire
